// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/kstt_pkg.sv =====
// ---------------------------------------------------------------------------
// kstt_pkg
// Shared codes, widths and types of the keyed timer table.
// ---------------------------------------------------------------------------
package kstt_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int KEY_BITS_DEF   = 16;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int NOW_W  = 63;
  localparam int KEY_W  = 16;
  localparam int PER_W  = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int SEQ_W  = 32;
  localparam int DL_W   = 64;
  localparam int PUS_W  = 42;   // period in microseconds

  localparam logic [9:0] MS_TO_US = 10'd1000;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BACKWARD  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_EXPIRE,
    S_MUL,
    S_DIV,
    S_DIV_WAIT,
    S_ADVANCE,
    S_NEXT,
    S_ARM,
    S_REPLY
  } state_t;

  // Remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [NOW_W-1:0] dividend;
    logic [PUS_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PUS_W-1:0] rem;
  } rem_rsp_t;

endpackage

// ===== design/keyed_software_timer_table.sv =====
// ---------------------------------------------------------------------------
// keyed_software_timer_table
// Table of keyed one-shot and periodic timers driven by tick, start and
// cancel commands; ticks report every due timer in index order.
// ---------------------------------------------------------------------------
//  channel | direction | fields                                           | flow
//  in      | to block  | action now_us timer_key timer_period repeat_mode | in_valid / in_stall
//  out     | from block| kind status expired_key sequence_res last        | out_valid / out_stall
//
// Start and cancel walk the slot memory, reading and then comparing each slot,
// then reply; a start that finds its slot arms it before the reply.
// Tick reads, checks and steps past each slot; a periodic expiry also runs
// the 63-step remainder unit that realigns its deadline.
// in_stall is high from the transfer until the last result is loaded into
// the output register; out_stall holds the sequencer while that register
// is full. Reset marks all slots inactive at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_software_timer_table #(
  parameter int NUM_TIMERS = kstt_pkg::NUM_TIMERS_DEF,
  parameter int KEY_BITS   = kstt_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kstt_pkg::ACT_W-1:0]   action,
  input  logic [kstt_pkg::NOW_W-1:0]   now_us,
  input  logic [kstt_pkg::KEY_W-1:0]   timer_key,
  input  logic [kstt_pkg::PER_W-1:0]   timer_period,
  input  logic                         repeat_mode,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kstt_pkg::KIND_W-1:0]  kind,
  output logic [kstt_pkg::STAT_W-1:0]  status,
  output logic [kstt_pkg::KEY_W-1:0]   expired_key,
  output logic [kstt_pkg::SEQ_W-1:0]   sequence_res,
  output logic                         last
);

  localparam int NW  = kstt_pkg::NOW_W;
  localparam int KW  = kstt_pkg::KEY_W;
  localparam int PW  = kstt_pkg::PER_W;
  localparam int UW  = kstt_pkg::PUS_W;
  localparam int SW  = kstt_pkg::SEQ_W;
  localparam int DW  = kstt_pkg::DL_W;
  localparam int SK  = (KEY_BITS < KW) ? KEY_BITS : KW;
  localparam int IW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  kstt_pkg::state_t state;
  kstt_pkg::state_t state_next;

  // Command registers
  logic [kstt_pkg::ACT_W-1:0] action_r;
  logic [NW-1:0]              now_r;
  logic [SK-1:0]              key_r;
  logic [PW-1:0]              period_r;
  logic                       mode_r;
  logic [UW-1:0]              pus;
  logic [DW-1:0]              npd;
  logic [NW-1:0]              current_time;
  logic [IW-1:0]              idx;
  logic [IW-1:0]              pick;
  logic                       free_found;
  logic [kstt_pkg::KIND_W-1:0] rep_kind;
  logic [kstt_pkg::STAT_W-1:0] rep_status;
  logic [NUM_TIMERS-1:0]      active;

  // Slot memory
  logic          mem_periodic [NUM_TIMERS];
  logic [SK-1:0] mem_key      [NUM_TIMERS];
  logic [PW-1:0] mem_period   [NUM_TIMERS];
  logic [SW-1:0] mem_seq      [NUM_TIMERS];
  logic [DW-1:0] mem_deadline [NUM_TIMERS];

  logic          rd_periodic;
  logic [SK-1:0] rd_key;
  logic [PW-1:0] rd_period;
  logic [SW-1:0] rd_seq;
  logic [DW-1:0] rd_deadline;

  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          wr_periodic;
  logic [SK-1:0] wr_key;
  logic [PW-1:0] wr_period;
  logic [SW-1:0] wr_seq;
  logic [DW-1:0] wr_deadline;

  // Output stage controls
  logic                        out_free;
  logic                        out_load;
  logic [kstt_pkg::KIND_W-1:0] kind_d;
  logic [kstt_pkg::STAT_W-1:0] status_d;
  logic [KW-1:0]               key_d;
  logic [SW-1:0]               seq_d;
  logic                        last_d;

  kstt_pkg::rem_req_t rem_req;
  kstt_pkg::rem_rsp_t rem_rsp;

  // Decode helpers
  logic          in_acc;
  logic [SK-1:0] key_m;
  logic          start_bad;
  logic          backward;
  logic          slot_act;
  logic          match;
  logic          at_last;
  logic          due;
  logic          keep_running;

  assign in_acc       = in_valid && !in_stall;
  assign key_m        = timer_key[SK-1:0];
  assign start_bad    = (key_m == '0) || (timer_period == '0);
  assign backward     = now_us < current_time;
  assign slot_act     = active[idx];
  assign match        = slot_act && (rd_key == key_r);
  assign at_last      = idx == LAST_IDX;
  assign due          = slot_act && ({1'b0, now_r} >= rd_deadline);
  assign keep_running = rd_periodic && (rd_period != '0);
  assign out_free     = !out_valid || !out_stall;

  kstt_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign rem_req.start    = (state == kstt_pkg::S_DIV);
  assign rem_req.dividend = NW'({1'b0, now_r} - rd_deadline);
  assign rem_req.divisor  = pus;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kstt_pkg::S_IDLE: begin
        if (in_acc) begin
          case (action)
            kstt_pkg::ACT_START:  state_next = start_bad ? kstt_pkg::S_REPLY : kstt_pkg::S_READ;
            kstt_pkg::ACT_CANCEL: state_next = kstt_pkg::S_READ;
            kstt_pkg::ACT_TICK:   state_next = backward ? kstt_pkg::S_REPLY : kstt_pkg::S_READ;
            default:              state_next = kstt_pkg::S_IDLE;
          endcase
        end
      end
      kstt_pkg::S_READ: state_next = kstt_pkg::S_EVAL;
      kstt_pkg::S_EVAL: begin
        case (action_r)
          kstt_pkg::ACT_START: begin
            if (match) begin
              state_next = kstt_pkg::S_ARM;
            end else if (at_last) begin
              state_next = (free_found || !slot_act) ? kstt_pkg::S_ARM : kstt_pkg::S_REPLY;
            end else begin
              state_next = kstt_pkg::S_READ;
            end
          end
          kstt_pkg::ACT_CANCEL: begin
            state_next = (match || at_last) ? kstt_pkg::S_REPLY : kstt_pkg::S_READ;
          end
          default: state_next = due ? kstt_pkg::S_EXPIRE : kstt_pkg::S_NEXT;
        endcase
      end
      kstt_pkg::S_EXPIRE: begin
        if (out_free) begin
          state_next = keep_running ? kstt_pkg::S_MUL : kstt_pkg::S_NEXT;
        end
      end
      kstt_pkg::S_MUL:      state_next = kstt_pkg::S_DIV;
      kstt_pkg::S_DIV:      state_next = kstt_pkg::S_DIV_WAIT;
      kstt_pkg::S_DIV_WAIT: begin
        if (rem_rsp.done) begin
          state_next = kstt_pkg::S_ADVANCE;
        end
      end
      kstt_pkg::S_ADVANCE:  state_next = kstt_pkg::S_NEXT;
      kstt_pkg::S_NEXT:     state_next = at_last ? kstt_pkg::S_REPLY : kstt_pkg::S_READ;
      kstt_pkg::S_ARM:      state_next = kstt_pkg::S_REPLY;
      kstt_pkg::S_REPLY: begin
        if (out_free) begin
          state_next = kstt_pkg::S_IDLE;
        end
      end
      default: state_next = kstt_pkg::S_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    in_stall    = (state != kstt_pkg::S_IDLE);
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_periodic = rd_periodic;
    wr_key      = rd_key;
    wr_period   = rd_period;
    wr_seq      = rd_seq + 1'b1;
    wr_deadline = npd - DW'(rem_rsp.rem);
    out_load    = 1'b0;
    kind_d      = rep_kind;
    status_d    = rep_status;
    key_d       = '0;
    seq_d       = '0;
    last_d      = 1'b1;
    case (state)
      kstt_pkg::S_READ: rd_en = 1'b1;
      kstt_pkg::S_EXPIRE: begin
        out_load = out_free;
        kind_d   = kstt_pkg::KIND_EXPIRY;
        status_d = kstt_pkg::ST_OK;
        key_d    = KW'(rd_key);
        seq_d    = rd_seq;
        last_d   = 1'b0;
      end
      kstt_pkg::S_ADVANCE: wr_en = 1'b1;
      kstt_pkg::S_ARM: begin
        wr_en       = 1'b1;
        wr_addr     = pick;
        wr_periodic = mode_r;
        wr_key      = key_r;
        wr_period   = period_r;
        wr_seq      = '0;
        wr_deadline = {1'b0, current_time} + DW'(pus);
      end
      kstt_pkg::S_REPLY: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_periodic <= mem_periodic[idx];
      rd_key      <= mem_key[idx];
      rd_period   <= mem_period[idx];
      rd_seq      <= mem_seq[idx];
      rd_deadline <= mem_deadline[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_periodic[wr_addr] <= wr_periodic;
      mem_key[wr_addr]      <= wr_key;
      mem_period[wr_addr]   <= wr_period;
      mem_seq[wr_addr]      <= wr_seq;
      mem_deadline[wr_addr] <= wr_deadline;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kstt_pkg::S_IDLE;
      active       <= '0;
      current_time <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc && (action == kstt_pkg::ACT_TICK) && !backward) begin
        current_time <= now_us;
      end
      case (state)
        kstt_pkg::S_EVAL: begin
          // free the matching slot on cancel
          if ((action_r == kstt_pkg::ACT_CANCEL) && match) begin
            active[idx] <= 1'b0;
          end
        end
        kstt_pkg::S_EXPIRE: begin
          if (out_free && !keep_running) begin
            active[idx] <= 1'b0;
          end
        end
        kstt_pkg::S_ARM: active[pick] <= 1'b1;
        default: ;
      endcase
    end
  end

  // Command and scan datapath
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind         <= kind_d;
      status       <= status_d;
      expired_key  <= key_d;
      sequence_res <= seq_d;
      last         <= last_d;
    end
    case (state)
      kstt_pkg::S_IDLE: begin
        if (in_acc) begin
          action_r   <= action;
          now_r      <= now_us;
          key_r      <= key_m;
          period_r   <= timer_period;
          mode_r     <= repeat_mode;
          pus        <= UW'(timer_period) * UW'(kstt_pkg::MS_TO_US);
          idx        <= '0;
          free_found <= 1'b0;
          rep_status <= kstt_pkg::ST_OK;
          case (action)
            kstt_pkg::ACT_START: begin
              rep_kind <= kstt_pkg::KIND_START;
              if (start_bad) begin
                rep_status <= kstt_pkg::ST_INVALID;
              end
            end
            kstt_pkg::ACT_CANCEL: rep_kind <= kstt_pkg::KIND_CANCEL;
            default: begin
              rep_kind <= kstt_pkg::KIND_DONE;
              if (backward) begin
                rep_status <= kstt_pkg::ST_BACKWARD;
              end
            end
          endcase
        end
      end
      kstt_pkg::S_EVAL: begin
        case (action_r)
          kstt_pkg::ACT_START: begin
            if (match) begin
              pick <= idx;
            end else begin
              // remember the lowest free slot
              if (!slot_act && !free_found) begin
                pick       <= idx;
                free_found <= 1'b1;
              end
              if (at_last) begin
                if (!(free_found || !slot_act)) begin
                  rep_status <= kstt_pkg::ST_NO_FREE;
                end
              end else begin
                idx <= idx + 1'b1;
              end
            end
          end
          kstt_pkg::ACT_CANCEL: begin
            if (!match) begin
              if (at_last) begin
                rep_status <= kstt_pkg::ST_NOT_FOUND;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      kstt_pkg::S_MUL: pus <= UW'(rd_period) * UW'(kstt_pkg::MS_TO_US);
      kstt_pkg::S_DIV: npd <= {1'b0, now_r} + DW'(pus);
      kstt_pkg::S_NEXT: begin
        if (!at_last) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Checks
  `ASSERT_NEXT(a_tick_time, clk, rst, in_valid && !in_stall && (action == kstt_pkg::ACT_TICK) && (now_us >= current_time), current_time == $past(now_us), "tick did not update the stored time")
  `ASSERT_SAME(a_rem_owned, clk, rst, rem_rsp.busy || rem_rsp.done, state == kstt_pkg::S_DIV_WAIT, "remainder unit running outside its wait state")
  `ASSERT_SAME(a_expiry_not_last, clk, rst, out_valid && (kind == kstt_pkg::KIND_EXPIRY), !last, "expiry flagged as last result")
  `ASSERT_SAME(a_reply_last, clk, rst, out_valid && (kind != kstt_pkg::KIND_EXPIRY), last, "reply or done not flagged as last result")

endmodule

// ===== design/kstt_rem_unit.sv =====
// ---------------------------------------------------------------------------
// kstt_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module kstt_rem_unit (
  input  logic               clk,
  input  logic               rst,
  input  kstt_pkg::rem_req_t req,
  output kstt_pkg::rem_rsp_t rsp
);

  localparam int NW    = kstt_pkg::NOW_W;
  localparam int PW    = kstt_pkg::PUS_W;
  localparam int CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NW - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    dvd;
  logic [PW-1:0]    dsr;
  logic [PW-1:0]    rem;
  logic [PW-1:0]    rem_next;
  logic [PW:0]      trial;
  logic [PW:0]      trial_sub;

  always_comb begin
    trial     = {rem, dvd[NW-1]};
    trial_sub = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      rem_next = trial_sub[PW-1:0];
    end else begin
      rem_next = trial[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[NW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule
